>>> rtl/i8dq_pkg.sv
// i8dq_pkg: constants for the int8 group dequantiser with binary16 scale.
// No dependencies.
`timescale 1ns / 1ps
package i8dq_pkg;
    localparam logic [31:0] QNAN_BITS     = 32'h7FC0_0000;
    localparam logic [31:0] F32_EXP_MASK  = 32'h7F80_0000;
    localparam logic [31:0] F32_QUIET_BIT = 32'h0040_0000;
    localparam logic [7:0]  EXP_OFFSET    = 8'd102;
    localparam int          PROD_W        = 19;
    localparam int          LZ_W          = 5;
endpackage

>>> rtl/i8dq_mul.sv
// i8dq_mul: binary16 scale decode and exact multiply by a signed 8-bit code.
// Depends on i8dq_pkg.
`timescale 1ns / 1ps
module i8dq_mul
    import i8dq_pkg::*;
(
    input  logic [7:0]  code,
    input  logic [15:0] scale_half,
    output logic [31:0] value_bits
);
    logic              h_sign;
    logic [4:0]        h_exp;
    logic [9:0]        h_man;
    logic [4:0]        e_eff;
    logic [10:0]       sig;
    logic              q_neg;
    logic [7:0]        q_mag;
    logic [PROD_W-1:0] prod;
    logic [LZ_W-1:0]   lead;
    logic [41:0]       shifted;
    logic              r_sign;
    logic [7:0]        r_exp;

    always_comb
    begin
        h_sign  = scale_half[15];
        h_exp   = scale_half[14:10];
        h_man   = scale_half[9:0];
        e_eff   = (h_exp == 5'd0) ? 5'd1 : h_exp;
        sig     = {(h_exp != 5'd0), h_man};
        q_neg   = code[7];
        q_mag   = q_neg ? (8'd0 - code) : code;
        prod    = PROD_W'(q_mag) * PROD_W'(sig);
        lead    = '0;
        for (int i = 0; i < PROD_W; i++)
        begin
            if (prod[i])
                lead = LZ_W'(i);
        end
        shifted = {23'd0, prod} << (LZ_W'(23) - lead);
        r_sign  = h_sign ^ q_neg;
        r_exp   = {3'd0, e_eff} + EXP_OFFSET + {3'd0, lead};

        if (h_exp == 5'h1F)
        begin
            if (h_man != 10'd0)
                value_bits = {h_sign, F32_EXP_MASK[30:0]} | {9'd0, h_man, 13'd0}
                             | F32_QUIET_BIT;
            else if (code == 8'd0)
                value_bits = QNAN_BITS;
            else
                value_bits = {r_sign, F32_EXP_MASK[30:0]};
        end
        else if (prod == '0)
            value_bits = {r_sign, 31'd0};
        else
            value_bits = {r_sign, r_exp, shifted[22:0]};
    end
endmodule

>>> rtl/i8dq_minmax.sv
// i8dq_minmax: next running row minimum and maximum in binary32 ordering.
// Depends on i8dq_pkg.
`timescale 1ns / 1ps
module i8dq_minmax
    import i8dq_pkg::*;
(
    input  logic [31:0] value_bits,
    input  logic        first_of_row,
    input  logic [31:0] cur_min,
    input  logic [31:0] cur_max,
    output logic [31:0] next_min,
    output logic [31:0] next_max
);
    function automatic logic f32_lt(input logic [31:0] a, input logic [31:0] b);
        logic a_nan;
        logic b_nan;
        logic [31:0] ka;
        logic [31:0] kb;
        a_nan = ((a & F32_EXP_MASK) == F32_EXP_MASK) && (a[22:0] != 23'd0);
        b_nan = ((b & F32_EXP_MASK) == F32_EXP_MASK) && (b[22:0] != 23'd0);
        ka = a[31] ? ~a : {1'b1, a[30:0]};
        kb = b[31] ? ~b : {1'b1, b[30:0]};
        if (a_nan || b_nan)
            return 1'b0;
        if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0))
            return 1'b0;
        return ka < kb;
    endfunction

    always_comb
    begin
        if (first_of_row)
        begin
            next_min = value_bits;
            next_max = value_bits;
        end
        else
        begin
            next_min = f32_lt(value_bits, cur_min) ? value_bits : cur_min;
            next_max = f32_lt(cur_max, value_bits) ? value_bits : cur_max;
        end
    end
endmodule

>>> rtl/int8_group_dequant_f16_scale.sv
// int8_group_dequant_f16_scale: int8 code times binary16 scale, binary32 out,
// with running row min and max. Depends on i8dq_pkg, i8dq_mul, i8dq_minmax.
// Input register, then result register; one request per cycle unless
// out_stall holds a full result register. Min/max feedback is combinational.
// Reset clears valid flags only; min/max are undefined until a row starts.
`timescale 1ns / 1ps
module int8_group_dequant_f16_scale
    import i8dq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  code,
    input  logic [15:0] scale_half,
    input  logic        first_of_row,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] value_bits,
    output logic [31:0] row_min_bits,
    output logic [31:0] row_max_bits
);
    logic        s1_valid_reg;
    logic [7:0]  code_reg;
    logic [15:0] scale_reg;
    logic        first_reg;
    logic        out_valid_reg;
    logic [31:0] value_reg;
    logic [31:0] min_reg;
    logic [31:0] max_reg;
    logic [31:0] value_next;
    logic [31:0] min_next;
    logic [31:0] max_next;
    logic        out_free;
    logic        advance;

    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;

    i8dq_mul u_mul
    (
        .code       (code_reg),
        .scale_half (scale_reg),
        .value_bits (value_next)
    );

    i8dq_minmax u_minmax
    (
        .value_bits   (value_next),
        .first_of_row (first_reg),
        .cur_min      (min_reg),
        .cur_max      (max_reg),
        .next_min     (min_next),
        .next_max     (max_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                s1_valid_reg <= in_valid;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            code_reg  <= code;
            scale_reg <= scale_half;
            first_reg <= first_of_row;
        end
        if (advance)
        begin
            value_reg <= value_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign value_bits   = value_reg;
    assign row_min_bits = min_reg;
    assign row_max_bits = max_reg;
endmodule

>>> dv/int8_group_dequant_f16_scale_tb.sv
// Testbench for int8_group_dequant_f16_scale: directed scale corner cases, row min/max
// tracking and random rows under sender/receiver idling. Depends on i8dq_pkg and the RTL.
`timescale 1ns / 1ps
module int8_group_dequant_f16_scale_tb;
    import i8dq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  code;
    logic [15:0] scale_half;
    logic        first_of_row;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] value_bits;
    logic [31:0] row_min_bits;
    logic [31:0] row_max_bits;

    typedef struct packed {
        logic [31:0] value;
        logic [31:0] lo;
        logic [31:0] hi;
    } dequant_result_t;

    dequant_result_t pending_results[$];
    logic [31:0] row_lo;
    logic [31:0] row_hi;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          cycles;
    int          errors;
    int          requests;
    int          results_seen;

    int8_group_dequant_f16_scale u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .code         (code),
        .scale_half   (scale_half),
        .first_of_row (first_of_row),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .value_bits   (value_bits),
        .row_min_bits (row_min_bits),
        .row_max_bits (row_max_bits)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // exact product: |code| * half significand * 2^e always fits binary32 normal range
    function automatic logic [31:0] dequant_value(logic [7:0] c, logic [15:0] h);
        logic        sgn;
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [7:0]  mag;
        logic [10:0] sig;
        int          e2;
        logic [18:0] prod;
        int          msb;
        logic [22:0] frac;
        sgn = h[15] ^ c[7];
        ex  = h[14:10];
        man = h[9:0];
        mag = c[7] ? (~c + 8'd1) : c;
        if (ex == 5'h1F)
        begin
            if (man != 0)
                return {h[15], 8'hFF, man, 13'b0} | F32_QUIET_BIT;
            if (c == 8'd0)
                return QNAN_BITS;
            return {sgn, 8'hFF, 23'b0};
        end
        if (ex == 5'd0)
        begin
            sig = {1'b0, man};
            e2  = -24;
        end
        else
        begin
            sig = {1'b1, man};
            e2  = int'(ex) - 25;
        end
        prod = mag * sig;
        if (prod == 0)
            return {sgn, 31'b0};
        msb = 0;
        for (int i = 0; i < 19; i++)
            if (prod[i])
                msb = i;
        frac = 23'((32'(prod) << (23 - msb)) & 32'h007F_FFFF);
        return {sgn, 8'(msb + e2 + 127), frac};
    endfunction

    function automatic bit is_nan(logic [31:0] f);
        return f[30:23] == 8'hFF && f[22:0] != 0;
    endfunction

    function automatic bit float_less(logic [31:0] a, logic [31:0] b);
        logic [31:0] ka;
        logic [31:0] kb;
        if (is_nan(a) || is_nan(b))
            return 1'b0;
        if (a[30:0] == 0 && b[30:0] == 0)
            return 1'b0;
        ka = a[31] ? ~a : (a | 32'h8000_0000);
        kb = b[31] ? ~b : (b | 32'h8000_0000);
        return ka < kb;
    endfunction

    task automatic send_request(logic [7:0] c, logic [15:0] h, logic first);
        dequant_result_t r;
        int gap;
        in_valid     <= 1'b1;
        code         <= c;
        scale_half   <= h;
        first_of_row <= first;
        do
            @(posedge clk);
        while (in_stall);
        r.value = dequant_value(c, h);
        if (first)
        begin
            row_lo = r.value;
            row_hi = r.value;
        end
        else
        begin
            if (float_less(r.value, row_lo))
                row_lo = r.value;
            if (float_less(row_hi, r.value))
                row_hi = r.value;
        end
        r.lo = row_lo;
        r.hi = row_hi;
        pending_results.push_back(r);
        requests++;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(4, 1);
            repeat (gap) @(posedge clk);
        end
    endtask

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
    begin
        dequant_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result value %h", $time, value_bits);
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (value_bits !== exp_r.value)
                begin
                    $display("%0t: value_bits expected %h got %h", $time, exp_r.value,
                             value_bits);
                    errors++;
                end
                if (row_min_bits !== exp_r.lo)
                begin
                    $display("%0t: row_min_bits expected %h got %h", $time, exp_r.lo,
                             row_min_bits);
                    errors++;
                end
                if (row_max_bits !== exp_r.hi)
                begin
                    $display("%0t: row_max_bits expected %h got %h", $time, exp_r.hi,
                             row_max_bits);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [15:0] pick_scale();
        case ($urandom_range(9))
            0: return {1'($urandom_range(1)), 5'h1F, 10'd0};
            1: return {1'($urandom_range(1)), 5'h1F, 10'($urandom_range(1023, 1))};
            2: return {1'($urandom_range(1)), 5'h00, 10'($urandom_range(1023))};
            3: return {1'($urandom_range(1)), 15'd0};
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_scale_corners();
        send_request(8'h7F, 16'h7BFF, 1'b1);
        send_request(8'h80, 16'h7BFF, 1'b0);
        send_request(8'h01, 16'h0001, 1'b0);
        send_request(8'hFF, 16'h83FF, 1'b0);
        send_request(8'h00, 16'h3C00, 1'b0);
        send_request(8'h05, 16'h8000, 1'b0);
        send_request(8'h05, 16'h0000, 1'b0);
        send_request(8'h03, 16'h7C00, 1'b0);
        send_request(8'hFD, 16'h7C00, 1'b0);
        send_request(8'h00, 16'hFC00, 1'b0);
        send_request(8'h11, 16'h7E00, 1'b0);
        send_request(8'h22, 16'hFC01, 1'b0);
        send_request(8'h80, 16'h0400, 1'b0);
    endtask

    task automatic test_row_tracking();
        send_request(8'h00, 16'h7D55, 1'b1);
        send_request(8'h10, 16'h3C00, 1'b0);
        send_request(8'h00, 16'h3C00, 1'b1);
        send_request(8'h00, 16'hBC00, 1'b0);
        send_request(8'hF0, 16'h3C00, 1'b0);
        send_request(8'h00, 16'h7E00, 1'b0);
        send_request(8'h40, 16'h4000, 1'b0);
        send_request(8'h01, 16'hFC00, 1'b0);
        send_request(8'h01, 16'h7C00, 1'b0);
        send_request(8'h80, 16'h4000, 1'b1);
    endtask

    task automatic test_random_rows(int n_requests);
        int          sent;
        int          row_len;
        logic [15:0] group_scale;
        sent = 0;
        while (sent < n_requests)
        begin
            row_len = $urandom_range(32, 1);
            group_scale = pick_scale();
            for (int i = 0; i < row_len; i++)
            begin
                if ($urandom_range(7) == 0)
                    group_scale = pick_scale();
                send_request(8'($urandom), group_scale, i == 0);
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        code           = 8'd0;
        scale_half     = 16'd0;
        first_of_row   = 1'b0;
        out_stall      = 1'b0;
        send_idle_pct  = 24;
        recv_stall_pct = 50;
        cycles         = 0;
        errors         = 0;
        requests       = 0;
        results_seen   = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_scale_corners();
        test_row_tracking();
        test_random_rows(260);
        send_idle_pct  = 50;
        recv_stall_pct = 24;
        test_random_rows(260);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_rows(260);
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d requests (scale corners, row min/max, random rows)", requests);
        $display("Checked %0d results; idling sender 24/receiver 50, 50/24, none",
                 results_seen);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> filelist.f
rtl/i8dq_pkg.sv
rtl/i8dq_mul.sv
rtl/i8dq_minmax.sv
rtl/int8_group_dequant_f16_scale.sv
dv/int8_group_dequant_f16_scale_tb.sv
